@@ sv/flv_tag_segmenter_unit_defines.svh @@
// Assertion macros for the file that checks its own logic.
`ifndef FLV_TAG_SEGMENTER_UNIT_DEFINES_SVH
`define FLV_TAG_SEGMENTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fts assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fts assertion failed");

`endif

@@ sv/fts_pkg.sv @@
package fts_pkg;

  localparam int unsigned POS_W      = 25;
  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned REC_W      = 25;
  localparam int unsigned HDR_W      = 26;
  localparam int unsigned TIME_W     = 33;
  localparam int unsigned NAME_W     = 40;
  localparam int unsigned SEC_W      = 16;
  localparam int unsigned THR_W      = 26;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [POS_W-1:0] FILE_HEAD_LAST = POS_W'(12);
  localparam logic [POS_W-1:0] TAG_END_MIN    = POS_W'(14);
  localparam logic [REC_W-1:0] FILE_HEAD_LEN  = REC_W'(13);
  localparam logic [REC_W-1:0] TAG_OVERHEAD   = REC_W'(15);

  localparam logic [7:0] TYPE_AUDIO = 8'd8;
  localparam logic [7:0] TYPE_VIDEO = 8'd9;
  localparam logic [7:0] TYPE_META  = 8'd18;
  localparam logic [3:0] CODEC_AVC  = 4'd7;
  localparam logic [3:0] SOUND_AAC  = 4'd10;
  localparam logic [3:0] FRAME_KEY  = 4'd1;
  localparam logic [7:0] PKT_SEQ_HEADER = 8'd0;

  localparam logic [SEC_W-1:0] DEFAULT_SECONDS = SEC_W'(5);
  localparam logic [THR_W-1:0] MS_PER_SEC      = THR_W'(1000);

  localparam logic CFG_SEGMENT_SECONDS = 1'b0;
  localparam logic CFG_START_NAME      = 1'b1;

  typedef enum logic [2:0] {
    DISP_FILE_HEAD   = 3'd0,
    DISP_VIDEO_SEQ   = 3'd1,
    DISP_AUDIO_SEQ   = 3'd2,
    DISP_META        = 3'd3,
    DISP_WRITE       = 3'd4,
    DISP_HDR_WRITE   = 3'd5,
    DISP_NEW_SEGMENT = 3'd6
  } disp_t;

  typedef struct packed {
    logic              head_done;
    logic              tag_done;
    logic [7:0]        tag_code;
    logic [SIZE_W-1:0] body_size;
    logic [31:0]       timestamp;
    logic [7:0]        flag;
    logic [7:0]        pkt;
    logic [23:0]       cts;
  } frame_t;

  typedef struct packed {
    logic [2:0]        disposition;
    logic [7:0]        tag_code;
    logic [SIZE_W-1:0] body_size;
    logic [REC_W-1:0]  record_length;
    logic [TIME_W-1:0] tag_time;
    logic              key_frame;
    logic [HDR_W-1:0]  header_length;
    logic [NAME_W-1:0] segment_name;
  } result_t;

  typedef struct packed {
    logic                  en;
    logic                  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

@@ sv/fts_ifs.sv @@
interface fts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fts_result_if;
  logic         valid;
  logic         ready;
  logic [2:0]   disposition;
  logic [7:0]   tag_code;
  logic [23:0]  body_size;
  logic [24:0]  record_length;
  logic [32:0]  tag_time;
  logic         key_frame;
  logic [25:0]  header_length;
  logic [39:0]  segment_name;
  modport source (output valid, output disposition, output tag_code, output body_size,
                  output record_length, output tag_time, output key_frame,
                  output header_length, output segment_name, input ready);
  modport sink (input valid, input disposition, input tag_code, input body_size,
                input record_length, input tag_time, input key_frame,
                input header_length, input segment_name, output ready);
endinterface

interface fts_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [39:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/fts_in_reg.sv @@
module fts_in_reg
  import fts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       fire,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       vld_r;
  logic [7:0] byte_r;

  // The stage can take a beat when it is empty or drains in this cycle.
  assign in_ready   = !vld_r || fire;
  assign hold_valid = vld_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule

@@ sv/fts_framer.sv @@
module fts_framer
  import fts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  output frame_t     frame
);

  logic              in_head_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [31:0]       ts_r, ts_nxt;
  logic [39:0]       fb_r, fb_nxt;
  logic              head_done, tag_done;

  // Field capture including the current byte, so the last byte of a short
  // record still lands in the flag, packet type and cts fields.
  always_comb begin
    type_nxt = type_r;
    size_nxt = size_r;
    ts_nxt   = ts_r;
    fb_nxt   = fb_r;
    if (!in_head_r) begin
      priority if (pos_r == POS_W'(0)) begin
        type_nxt = data_byte;
        size_nxt = '0;
        ts_nxt   = '0;
        fb_nxt   = '0;
      end else if (pos_r <= POS_W'(3)) begin
        size_nxt = {size_r[15:0], data_byte};
      end else if (pos_r == POS_W'(4)) begin
        ts_nxt[23:16] = ts_r[23:16] | data_byte;
      end else if (pos_r == POS_W'(5)) begin
        ts_nxt[15:8] = ts_r[15:8] | data_byte;
      end else if (pos_r == POS_W'(6)) begin
        ts_nxt[7:0] = ts_r[7:0] | data_byte;
      end else if (pos_r == POS_W'(7)) begin
        ts_nxt[31:24] = ts_r[31:24] | data_byte;
      end else if (pos_r == POS_W'(11)) begin
        fb_nxt[39:32] = fb_r[39:32] | data_byte;
      end else if (pos_r == POS_W'(12)) begin
        fb_nxt[31:24] = fb_r[31:24] | data_byte;
      end else if (pos_r == POS_W'(13)) begin
        fb_nxt[23:16] = fb_r[23:16] | data_byte;
      end else if (pos_r == POS_W'(14)) begin
        fb_nxt[15:8] = fb_r[15:8] | data_byte;
      end else if (pos_r == POS_W'(15)) begin
        fb_nxt[7:0] = fb_r[7:0] | data_byte;
      end else begin
        fb_nxt = fb_r;
      end
    end
  end

  assign head_done = in_head_r && (pos_r >= FILE_HEAD_LAST);
  // The tag record ends on its last trailer byte, at position size plus 14.
  assign tag_done  = !in_head_r && (pos_r >= TAG_END_MIN) &&
                     (pos_r == ({1'b0, size_r} + TAG_END_MIN));

  always_comb begin
    if (head_done || tag_done) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign frame.head_done = head_done;
  assign frame.tag_done  = tag_done;
  assign frame.tag_code  = type_nxt;
  assign frame.body_size = size_nxt;
  assign frame.timestamp = ts_nxt;
  assign frame.flag      = fb_nxt[39:32];
  assign frame.pkt       = fb_nxt[31:24];
  assign frame.cts       = fb_nxt[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_head_r <= 1'b1;
      pos_r     <= '0;
      type_r    <= '0;
      size_r    <= '0;
      ts_r      <= '0;
      fb_r      <= '0;
    end else if (fire) begin
      if (head_done) begin
        in_head_r <= 1'b0;
      end
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      size_r <= size_nxt;
      ts_r   <= ts_nxt;
      fb_r   <= fb_nxt;
    end
  end

endmodule

@@ sv/fts_tag_class.sv @@
module fts_tag_class
  import fts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  frame_t  frame,
  input  cfg_wr_t cfg_wr,
  output result_t result
);

  logic [SEC_W-1:0]  eff_r;
  logic [THR_W-1:0]  thr_r;
  logic [HDR_W-1:0]  hdr_len_r, hdr_len_nxt;
  logic [2:0]        found_r, found_nxt;
  logic              hdr_written_r, hdr_written_nxt;
  logic [TIME_W-1:0] last_cut_r, last_cut_nxt;
  logic              cut_valid_r, cut_valid_nxt;
  logic [NAME_W-1:0] name_r, name_nxt;

  logic [SEC_W-1:0]  cfg_eff;
  logic [REC_W-1:0]  rec;
  logic              is_video, is_avc, key;
  logic [TIME_W-1:0] t;
  logic [TIME_W:0]   cut_limit;
  logic              cut;
  disp_t             disp;

  assign cfg_eff   = (cfg_wr.data[SEC_W-1:0] == '0) ? DEFAULT_SECONDS
                                                     : cfg_wr.data[SEC_W-1:0];
  assign rec       = REC_W'(frame.body_size) + TAG_OVERHEAD;
  assign is_video  = (frame.tag_code == TYPE_VIDEO);
  assign is_avc    = is_video && (frame.flag[3:0] == CODEC_AVC);
  assign key       = is_avc && (frame.flag[7:4] == FRAME_KEY);
  assign t         = TIME_W'(frame.timestamp) + (is_avc ? TIME_W'(frame.cts) : '0);
  assign cut_limit = {1'b0, last_cut_r} + (TIME_W+1)'(thr_r);
  assign cut       = key && cut_valid_r && ({1'b0, t} >= cut_limit);

  always_comb begin
    hdr_len_nxt     = hdr_len_r;
    found_nxt       = found_r;
    hdr_written_nxt = hdr_written_r;
    last_cut_nxt    = last_cut_r;
    cut_valid_nxt   = cut_valid_r;
    name_nxt        = name_r;
    disp            = DISP_WRITE;
    priority if (is_avc && !found_r[0] && frame.pkt == PKT_SEQ_HEADER) begin
      disp         = DISP_VIDEO_SEQ;
      found_nxt[0] = 1'b1;
      hdr_len_nxt  = hdr_len_r + HDR_W'(rec);
    end else if (frame.tag_code == TYPE_AUDIO && frame.flag[7:4] == SOUND_AAC &&
                 !found_r[1] && frame.pkt == PKT_SEQ_HEADER) begin
      disp         = DISP_AUDIO_SEQ;
      found_nxt[1] = 1'b1;
      hdr_len_nxt  = hdr_len_r + HDR_W'(rec);
    end else if (frame.tag_code == TYPE_META && !found_r[2]) begin
      disp         = DISP_META;
      found_nxt[2] = 1'b1;
      hdr_len_nxt  = hdr_len_r + HDR_W'(rec);
    end else begin
      hdr_written_nxt = 1'b1;
      disp            = hdr_written_r ? DISP_WRITE : DISP_HDR_WRITE;
      if (is_video) begin
        // The first written video tag sets the cut reference.
        if (!cut_valid_r) begin
          last_cut_nxt  = t;
          cut_valid_nxt = 1'b1;
        end
        if (cut) begin
          name_nxt     = name_r + NAME_W'(eff_r);
          last_cut_nxt = t;
          disp         = DISP_NEW_SEGMENT;
        end
      end
    end
  end

  always_comb begin
    if (frame.head_done) begin
      result.disposition   = DISP_FILE_HEAD;
      result.tag_code      = '0;
      result.body_size     = '0;
      result.record_length = FILE_HEAD_LEN;
      result.tag_time      = '0;
      result.key_frame     = 1'b0;
      result.header_length = hdr_len_r;
      result.segment_name  = name_r;
    end else begin
      result.disposition   = disp;
      result.tag_code      = frame.tag_code;
      result.body_size     = frame.body_size;
      result.record_length = rec;
      result.tag_time      = t;
      result.key_frame     = key;
      result.header_length = hdr_len_nxt;
      result.segment_name  = name_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r         <= DEFAULT_SECONDS;
      thr_r         <= THR_W'(DEFAULT_SECONDS) * MS_PER_SEC;
      hdr_len_r     <= HDR_W'(FILE_HEAD_LEN);
      found_r       <= '0;
      hdr_written_r <= 1'b0;
      last_cut_r    <= '0;
      cut_valid_r   <= 1'b0;
      name_r        <= '0;
    end else if (cfg_wr.en) begin
      if (cfg_wr.index == CFG_SEGMENT_SECONDS) begin
        eff_r <= cfg_eff;
        thr_r <= THR_W'(cfg_eff) * MS_PER_SEC;
      end else begin
        name_r <= cfg_wr.data[NAME_W-1:0];
      end
    end else if (fire && frame.tag_done) begin
      hdr_len_r     <= hdr_len_nxt;
      found_r       <= found_nxt;
      hdr_written_r <= hdr_written_nxt;
      last_cut_r    <= last_cut_nxt;
      cut_valid_r   <= cut_valid_nxt;
      name_r        <= name_nxt;
    end
  end

endmodule

@@ sv/flv_tag_segmenter_unit.sv @@
// Each byte beat is held in the input register, each result in the output register.
// Throughput: one byte beat per cycle, sustained; the classify stage only pauses
// when a result is due and the output register is still full.
// Reset: rst_n is synchronous, active low; it empties both stages, restores the
// file-head skip, segment length 5 s and segment name 0.
`include "flv_tag_segmenter_unit_defines.svh"

module flv_tag_segmenter_unit
  import fts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fts_byte_if.sink     in_s,
  fts_result_if.source out_m,
  fts_cfg_if.sink      cfg_s
);

  // Stage one is a plain input register. Stage two holds the framing and
  // classification state; its combinational logic turns the registered byte
  // into the next state and, on the last byte of a record, into a result.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       in_ready;
  logic       fire;
  logic       has_result;
  logic       out_free;
  frame_t     frame;
  result_t    result;
  cfg_wr_t    cfg_wr;

  logic    out_valid_r;
  result_t out_res_r;

  // The config port never stalls; the user must write only while idle (unchecked).
  assign cfg_s.ready = 1'b1;
  assign cfg_wr.en    = cfg_s.valid;
  assign cfg_wr.index = cfg_s.index;
  assign cfg_wr.data  = cfg_s.data;

  assign has_result = frame.head_done || frame.tag_done;
  assign out_free   = !out_valid_r || out_m.ready;
  // A byte that completes nothing moves on even while a result waits.
  assign fire       = hold_valid && (!has_result || out_free);

  fts_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_s.valid),
    .in_ready   (in_ready),
    .in_byte    (in_s.data_byte),
    .fire       (fire),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  assign in_s.ready = in_ready;

  fts_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (hold_byte),
    .frame     (frame)
  );

  fts_tag_class u_tag_class (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .frame  (frame),
    .cfg_wr (cfg_wr),
    .result (result)
  );

  // Output register: it separates the result beat from the input side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_res_r <= result;
    end
  end

  assign out_m.valid         = out_valid_r;
  assign out_m.disposition   = out_res_r.disposition;
  assign out_m.tag_code      = out_res_r.tag_code;
  assign out_m.body_size     = out_res_r.body_size;
  assign out_m.record_length = out_res_r.record_length;
  assign out_m.tag_time      = out_res_r.tag_time;
  assign out_m.key_frame     = out_res_r.key_frame;
  assign out_m.header_length = out_res_r.header_length;
  assign out_m.segment_name  = out_res_r.segment_name;

  // A new segment is only ever opened on a keyframe.
  `FTS_ASSERT_NOW(a_cut_on_key, clk, rst_n,
    out_valid_r && out_res_r.disposition == DISP_NEW_SEGMENT, out_res_r.key_frame)
  // Every tag record spans its header, body and trailer.
  `FTS_ASSERT_NOW(a_rec_len, clk, rst_n,
    out_valid_r && out_res_r.disposition != DISP_FILE_HEAD,
    out_res_r.record_length == (REC_W'(out_res_r.body_size) + TAG_OVERHEAD))
  // A byte held back by a full output stays in the input register unchanged.
  `FTS_ASSERT_NEXT(a_hold_byte, clk, rst_n,
    hold_valid && !fire, hold_valid && $stable(hold_byte))

endmodule

@@ sim/flv_tag_segmenter_unit_checker.sv @@
module flv_tag_segmenter_unit_checker
  import fts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fts_byte_if         byte_mon,
  fts_result_if       res_mon,
  fts_cfg_if          cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Record offsets of the tag header fields and of the leading body bytes.
  localparam logic [POS_W-1:0] OFS_TYPE     = POS_W'(0);
  localparam logic [POS_W-1:0] OFS_SIZE_HI  = POS_W'(1);
  localparam logic [POS_W-1:0] OFS_SIZE_MID = POS_W'(2);
  localparam logic [POS_W-1:0] OFS_SIZE_LO  = POS_W'(3);
  localparam logic [POS_W-1:0] OFS_TS_HI    = POS_W'(4);
  localparam logic [POS_W-1:0] OFS_TS_MID   = POS_W'(5);
  localparam logic [POS_W-1:0] OFS_TS_LO    = POS_W'(6);
  localparam logic [POS_W-1:0] OFS_TS_EXT   = POS_W'(7);
  localparam logic [POS_W-1:0] OFS_FLAG     = POS_W'(11);
  localparam logic [POS_W-1:0] OFS_PKT      = POS_W'(12);
  localparam logic [POS_W-1:0] OFS_CTS_HI   = POS_W'(13);
  localparam logic [POS_W-1:0] OFS_CTS_MID  = POS_W'(14);
  localparam logic [POS_W-1:0] OFS_CTS_LO   = POS_W'(15);

  logic              skipping_head;
  logic [POS_W-1:0]  rec_pos;
  logic [7:0]        tag_kind;
  logic [SIZE_W-1:0] tag_len;
  logic [31:0]       tag_stamp;
  logic [39:0]       lead_bytes;
  logic [REC_W-1:0]  video_seq_len;
  logic [REC_W-1:0]  audio_seq_len;
  logic [REC_W-1:0]  meta_len;
  logic              have_video_seq;
  logic              have_audio_seq;
  logic              have_meta;
  logic              header_sent;
  logic [TIME_W-1:0] last_video_ms;
  logic [TIME_W-1:0] last_cut_ms;
  logic              cut_armed;
  logic [NAME_W-1:0] seg_name;
  logic [SEC_W-1:0]  seg_seconds;
  result_t           tag_outcomes[$];
  int unsigned       errs = 0;

  function automatic logic [HDR_W-1:0] header_block_len();
    return HDR_W'(FILE_HEAD_LEN) + HDR_W'(video_seq_len) + HDR_W'(audio_seq_len)
           + HDR_W'(meta_len);
  endfunction

  function automatic void report_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      errs++;
    end
  endfunction

  // Classifies a completed tag record and updates the stored-header and cut state.
  task automatic classify_tag(output result_t r);
    logic [7:0]        flag;
    logic [7:0]        pkt;
    logic [23:0]       cts;
    logic [REC_W-1:0]  rec;
    logic [TIME_W-1:0] t;
    logic              key;
    logic              stored;
    logic [SEC_W-1:0]  eff;
    longint            gap_ms;
    disp_t             d;
    flag   = lead_bytes[39:32];
    pkt    = lead_bytes[31:24];
    cts    = lead_bytes[23:0];
    rec    = REC_W'(tag_len) + TAG_OVERHEAD;
    t      = TIME_W'(tag_stamp);
    key    = 1'b0;
    stored = 1'b0;
    d      = DISP_WRITE;
    eff    = (seg_seconds == '0) ? DEFAULT_SECONDS : seg_seconds;
    if (tag_kind == TYPE_VIDEO) begin
      if (flag[3:0] == CODEC_AVC) begin
        key = (flag[7:4] == FRAME_KEY);
        t   = t + TIME_W'(cts);
        if (!have_video_seq && pkt == PKT_SEQ_HEADER) begin
          video_seq_len  = rec;
          have_video_seq = 1'b1;
          stored         = 1'b1;
          d              = DISP_VIDEO_SEQ;
        end
      end
    end else if (tag_kind == TYPE_AUDIO) begin
      if (flag[7:4] == SOUND_AAC && !have_audio_seq && pkt == PKT_SEQ_HEADER) begin
        audio_seq_len  = rec;
        have_audio_seq = 1'b1;
        stored         = 1'b1;
        d              = DISP_AUDIO_SEQ;
      end
    end else if (tag_kind == TYPE_META) begin
      if (!have_meta) begin
        meta_len  = rec;
        have_meta = 1'b1;
        stored    = 1'b1;
        d         = DISP_META;
      end
    end
    if (!stored) begin
      if (!header_sent) begin
        header_sent = 1'b1;
        d           = DISP_HDR_WRITE;
      end
      if (tag_kind == TYPE_VIDEO) begin
        last_video_ms = t;
        if (!cut_armed) begin
          last_cut_ms = t;
          cut_armed   = 1'b1;
        end
        gap_ms = longint'({31'd0, last_video_ms}) - longint'({31'd0, last_cut_ms});
        if (key && gap_ms >= longint'(eff) * longint'(MS_PER_SEC)) begin
          seg_name    = seg_name + NAME_W'(eff);
          header_sent = 1'b1;
          last_cut_ms = t;
          d           = DISP_NEW_SEGMENT;
        end
      end
    end
    r               = '0;
    r.disposition   = d;
    r.tag_code      = tag_kind;
    r.body_size     = tag_len;
    r.record_length = rec;
    r.tag_time      = t;
    r.key_frame     = key;
    r.header_length = header_block_len();
    r.segment_name  = seg_name;
  endtask

  task automatic take_byte(input logic [7:0] b);
    result_t r;
    if (skipping_head) begin
      if (rec_pos >= FILE_HEAD_LAST) begin
        skipping_head   = 1'b0;
        rec_pos         = '0;
        r               = '0;
        r.disposition   = DISP_FILE_HEAD;
        r.record_length = FILE_HEAD_LEN;
        r.header_length = header_block_len();
        r.segment_name  = seg_name;
        tag_outcomes.push_back(r);
      end else begin
        rec_pos = rec_pos + POS_W'(1);
      end
    end else begin
      case (rec_pos)
        OFS_TYPE: begin
          tag_kind   = b;
          tag_len    = '0;
          tag_stamp  = '0;
          lead_bytes = '0;
        end
        OFS_SIZE_HI, OFS_SIZE_MID, OFS_SIZE_LO: tag_len = {tag_len[15:0], b};
        OFS_TS_HI:   tag_stamp[23:16] = b;
        OFS_TS_MID:  tag_stamp[15:8] = b;
        OFS_TS_LO:   tag_stamp[7:0] = b;
        OFS_TS_EXT:  tag_stamp[31:24] = b;
        OFS_FLAG:    lead_bytes[39:32] = b;
        OFS_PKT:     lead_bytes[31:24] = b;
        OFS_CTS_HI:  lead_bytes[23:16] = b;
        OFS_CTS_MID: lead_bytes[15:8] = b;
        OFS_CTS_LO:  lead_bytes[7:0] = b;
        default: ;
      endcase
      // The record closes on its last trailer byte; a short body lets the
      // trailer bytes stand in for the flag, packet type and cts bytes.
      if (rec_pos >= TAG_END_MIN && rec_pos == POS_W'(tag_len) + TAG_END_MIN) begin
        classify_tag(r);
        tag_outcomes.push_back(r);
        rec_pos = '0;
      end else begin
        rec_pos = rec_pos + POS_W'(1);
      end
    end
  endtask

  task automatic check_result();
    result_t want;
    if (tag_outcomes.size() == 0) begin
      $error("result beat with no expected result: disposition %0d, type 0x%0h",
             res_mon.disposition, res_mon.tag_code);
      errs++;
    end else begin
      want = tag_outcomes.pop_front();
      report_field("disposition", 64'(want.disposition), 64'(res_mon.disposition));
      report_field("tag_code", 64'(want.tag_code), 64'(res_mon.tag_code));
      report_field("body_size", 64'(want.body_size), 64'(res_mon.body_size));
      report_field("record_length", 64'(want.record_length),
                   64'(res_mon.record_length));
      report_field("tag_time", 64'(want.tag_time), 64'(res_mon.tag_time));
      report_field("key_frame", 64'(want.key_frame), 64'(res_mon.key_frame));
      report_field("header_length", 64'(want.header_length),
                   64'(res_mon.header_length));
      report_field("segment_name", 64'(want.segment_name), 64'(res_mon.segment_name));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      skipping_head  = 1'b1;
      rec_pos        = '0;
      tag_kind       = '0;
      tag_len        = '0;
      tag_stamp      = '0;
      lead_bytes     = '0;
      video_seq_len  = '0;
      audio_seq_len  = '0;
      meta_len       = '0;
      have_video_seq = 1'b0;
      have_audio_seq = 1'b0;
      have_meta      = 1'b0;
      header_sent    = 1'b0;
      last_video_ms  = '0;
      last_cut_ms    = '0;
      cut_armed      = 1'b0;
      seg_name       = '0;
      seg_seconds    = DEFAULT_SECONDS;
      tag_outcomes.delete();
    end else begin
      // Results leave the output register after their byte, so the oldest entry is
      // always compared before this edge's byte can add a new one.
      if (res_mon.valid && res_mon.ready) begin
        check_result();
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_SEGMENT_SECONDS) begin
          seg_seconds = cfg_mon.data[SEC_W-1:0];
        end else begin
          seg_name = cfg_mon.data[NAME_W-1:0];
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        take_byte(byte_mon.data_byte);
      end
    end
    mismatch_count  <= errs;
    results_pending <= tag_outcomes.size();
  end

endmodule

@@ sim/flv_tag_segmenter_unit_tb.sv @@
module flv_tag_segmenter_unit_tb;
  import fts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is bounded well above the slowest legal run: the stream bytes with
  // their random source gaps plus one long tag sent back to back.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Cycles the sink keeps ready low while the source keeps offering beats.
  localparam int unsigned SINK_HOLD   = 300;
  // Cycles allowed after the last expected result for bytes still in the pipe.
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_BYTES = 80;
  localparam int unsigned PHASE_TAGS  = 3;

  // Codes that the package does not name but the stimulus needs.
  localparam logic [7:0] TYPE_UNUSED  = 8'h00;
  localparam logic [7:0] TYPE_ALL_ONE = 8'hFF;
  localparam logic [3:0] FRAME_INTER  = 4'd2;
  localparam logic [3:0] CODEC_H263   = 4'd2;
  localparam logic [3:0] SOUND_RATE   = 4'hF;
  localparam logic [7:0] PKT_NALU     = 8'd1;
  localparam logic [SIZE_W-1:0] LONG_TAG_SIZE = SIZE_W'(24'h000123);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned bytes_sent = 0;
  int unsigned tags_sent = 0;
  logic [31:0] stream_ms = '0;

  // Idle switches, redrawn for every tag so that quiet and busy stretches mix.
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  bit sink_hold_req = 1'b0;

  fts_byte_if   byte_ch ();
  fts_result_if res_ch ();
  fts_cfg_if    cfg_ch ();

  flv_tag_segmenter_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (byte_ch),
    .out_m (res_ch),
    .cfg_s (cfg_ch)
  );

  // The checker watches all three channels, predicts each result and counts
  // every mismatch; the top only produces stimulus and reports the verdict.
  flv_tag_segmenter_unit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_mon        (byte_ch),
    .res_mon         (res_ch),
    .cfg_mon         (cfg_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result sink. Each beat waits a random number of cycles with ready low,
  // unless idling is switched off. On request it also holds ready low for a
  // long stretch so that the output register fills and the block stalls its
  // byte input while the source keeps offering.
  initial begin : result_sink
    int unsigned gap;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end
      gap = sink_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // Offers one stream byte and returns at the edge where its beat is taken.
  // The next call keeps valid high when it draws no gap, so valid is never
  // dropped and raised within one step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops offering bytes until every predicted result has come back, then
  // lets the pipeline settle so no byte without a result is still inside.
  task automatic wait_for_drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic program_segmenter(input logic [SEC_W-1:0] seconds,
                                   input logic [NAME_W-1:0] name);
    wait_for_drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_SEGMENT_SECONDS;
    cfg_ch.data  <= CFG_DATA_W'(seconds);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_START_NAME;
    cfg_ch.data  <= name;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sends one whole tag record: 11-byte header, body and 4-byte trailer.
  // The first body bytes carry the flag, the packet type and the cts. A noisy
  // tag has a random stream id and a trailer that does not match its size.
  task automatic send_tag(input logic [7:0] kind, input logic [SIZE_W-1:0] size,
                          input logic [31:0] stamp, input logic [7:0] flag,
                          input logic [7:0] pkt, input logic [23:0] cts,
                          input bit noisy, input bit calm);
    logic [31:0] prev_size;
    int unsigned j;
    prev_size = 32'(size) + 32'd11;
    src_idle  = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
    sink_idle = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
    send_byte(kind);
    send_byte(size[23:16]);
    send_byte(size[15:8]);
    send_byte(size[7:0]);
    send_byte(stamp[23:16]);
    send_byte(stamp[15:8]);
    send_byte(stamp[7:0]);
    send_byte(stamp[31:24]);
    repeat (3) send_byte(noisy ? 8'($urandom) : 8'h00);
    for (j = 0; j < size; j++) begin
      case (j)
        0:       send_byte(flag);
        1:       send_byte(pkt);
        2:       send_byte(cts[23:16]);
        3:       send_byte(cts[15:8]);
        4:       send_byte(cts[7:0]);
        default: send_byte(8'($urandom));
      endcase
    end
    if (noisy) begin
      repeat (4) send_byte(8'($urandom));
    end else begin
      send_byte(prev_size[31:24]);
      send_byte(prev_size[23:16]);
      send_byte(prev_size[15:8]);
      send_byte(prev_size[7:0]);
    end
    tags_sent++;
  endtask

  // A random tag from a plausible stream: time mostly moves forward in small
  // steps, with rare big jumps and rare arbitrary stamps (time going back).
  task automatic random_tag();
    int unsigned pick;
    logic [7:0]        kind;
    logic [7:0]        flag;
    logic [7:0]        pkt;
    logic [SIZE_W-1:0] size;
    logic [23:0]       cts;
    bit                noisy;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 15))
      0:       stream_ms = $urandom;
      1:       stream_ms = stream_ms + $urandom_range(0, 80_000_000);
      default: stream_ms = stream_ms + $urandom_range(0, 400);
    endcase
    size  = ($urandom_range(0, 39) == 0) ? SIZE_W'($urandom_range(100, 600))
                                         : SIZE_W'($urandom_range(0, 24));
    cts   = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200));
    noisy = ($urandom_range(0, 9) == 0);
    flag  = 8'($urandom);
    if (pick < 50) begin
      kind = TYPE_VIDEO;
      case ($urandom_range(0, 9))
        0, 1, 2: flag = {FRAME_KEY, CODEC_AVC};
        3:       flag = 8'($urandom);
        default: flag = {FRAME_INTER, CODEC_AVC};
      endcase
    end else if (pick < 78) begin
      kind = TYPE_AUDIO;
      if ($urandom_range(0, 3) != 0) begin
        flag = {SOUND_AAC, SOUND_RATE};
      end
    end else if (pick < 88) begin
      kind = TYPE_META;
    end else begin
      kind = 8'($urandom);
    end
    case ($urandom_range(0, 7))
      0:       pkt = PKT_SEQ_HEADER;
      1:       pkt = 8'($urandom);
      default: pkt = PKT_NALU;
    endcase
    send_tag(kind, size, stream_ms, flag, pkt, cts, noisy, 1'b0);
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned phase_mark;
    int unsigned tag_mark;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_SEGMENT_SECONDS;
    cfg_ch.data       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A one-second segment and the top segment name, so the
    // first cut wraps the name around to zero.
    program_segmenter(SEC_W'(1), {NAME_W{1'b1}});
    src_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (13) send_byte(8'($urandom));
    // The first metadata, AVC and AAC sequence headers are stored.
    send_tag(TYPE_META, 24'd20, 32'd0, 8'h00, 8'h00, 24'd0, 1'b0, 1'b0);
    send_tag(TYPE_VIDEO, 24'd40, 32'd0, {FRAME_KEY, CODEC_AVC}, PKT_SEQ_HEADER, 24'd0,
             1'b0, 1'b0);
    send_tag(TYPE_AUDIO, 24'd7, 32'd0, {SOUND_AAC, SOUND_RATE}, PKT_SEQ_HEADER, 24'd0,
             1'b0, 1'b0);
    // First written tag is prefixed by the header block and arms the cut time.
    send_tag(TYPE_VIDEO, 24'd30, 32'd0, {FRAME_KEY, CODEC_AVC}, PKT_NALU, 24'd0,
             1'b0, 1'b0);
    send_tag(TYPE_AUDIO, 24'd9, 32'd23, {SOUND_AAC, SOUND_RATE}, PKT_NALU, 24'd0,
             1'b0, 1'b0);
    send_tag(TYPE_VIDEO, 24'd12, 32'd900, {FRAME_INTER, CODEC_AVC}, PKT_NALU, 24'h40,
             1'b0, 1'b0);
    // A keyframe one millisecond short of the threshold, then one right on it.
    send_tag(TYPE_VIDEO, 24'd8, 32'd999, {FRAME_KEY, CODEC_AVC}, PKT_NALU, 24'd0,
             1'b0, 1'b0);
    send_tag(TYPE_VIDEO, 24'd8, 32'd1000, {FRAME_KEY, CODEC_AVC}, PKT_NALU, 24'd0,
             1'b0, 1'b0);
    // A keyframe of another codec never cuts and carries no cts.
    send_tag(TYPE_VIDEO, 24'd6, 32'd5000, {FRAME_KEY, CODEC_H263}, PKT_NALU, 24'h123,
             1'b0, 1'b0);
    // Empty and short bodies: the trailer bytes stand in for flag and cts.
    send_tag(TYPE_UNUSED, 24'd0, 32'd0, 8'h00, 8'h00, 24'd0, 1'b0, 1'b0);
    send_tag(TYPE_VIDEO, 24'd0, 32'd9000, 8'h00, 8'h00, 24'd0, 1'b0, 1'b0);
    send_tag(TYPE_VIDEO, 24'd2, 32'd9000, {FRAME_KEY, CODEC_AVC}, PKT_NALU, 24'd0,
             1'b0, 1'b0);
    // Largest stamp with the extension byte all ones plus the largest cts.
    send_tag(TYPE_VIDEO, 24'd5, 32'hFFFF_FFFF, {FRAME_KEY, CODEC_AVC}, PKT_NALU,
             24'hFF_FFFF, 1'b0, 1'b0);
    // Sequence headers and metadata seen again are plain writes.
    send_tag(TYPE_META, 24'd3, 32'd10, 8'hFF, 8'hFF, 24'd0, 1'b0, 1'b0);
    send_tag(TYPE_VIDEO, 24'd5, 32'd20, {FRAME_KEY, CODEC_AVC}, PKT_SEQ_HEADER, 24'd0,
             1'b0, 1'b0);
    send_tag(TYPE_AUDIO, 24'd5, 32'd30, {SOUND_AAC, SOUND_RATE}, PKT_SEQ_HEADER, 24'd0,
             1'b0, 1'b0);
    send_tag(TYPE_ALL_ONE, 24'd4, 32'd40, 8'hFF, 8'hFF, 24'hFF_FFFF, 1'b1, 1'b0);

    // Back pressure: the sink stops for a long stretch while short tags keep
    // coming, so results pile up and the byte input stalls. Afterwards the
    // source waits until every result is back.
    sink_hold_req = 1'b1;
    repeat (12) begin
      stream_ms = stream_ms + 40;
      send_tag(TYPE_VIDEO, 24'd0, stream_ms, 8'h00, 8'h00, 24'd0, 1'b0, 1'b1);
    end
    wait_for_drain();

    // Random phases, each with its own register setting, extremes included.
    stream_ms = 32'd20_000;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_segmenter(SEC_W'(0), {8'($urandom), 32'($urandom)});
        1: program_segmenter(SEC_W'(2), '0);
        2: program_segmenter({SEC_W{1'b1}}, {8'($urandom), 32'($urandom)});
        3: program_segmenter(SEC_W'($urandom_range(3, 30)), {{(NAME_W-4){1'b1}}, 4'h0});
        default: program_segmenter(SEC_W'(1), {8'($urandom), 32'($urandom)});
      endcase
      if (ph == 2) begin
        // One long tag, sent without gaps to keep the run short.
        send_tag(TYPE_VIDEO, LONG_TAG_SIZE, stream_ms, {FRAME_INTER, CODEC_AVC},
                 PKT_NALU, 24'd0, 1'b0, 1'b1);
      end
      phase_mark = bytes_sent;
      tag_mark   = tags_sent;
      while (bytes_sent - phase_mark < PHASE_BYTES || tags_sent - tag_mark < PHASE_TAGS) begin
        random_tag();
      end
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
